>>> rtl/csvqp_pkg.sv
`default_nettype none

package csvqp_pkg;

    localparam int SPACE_DEPTH = 15;
    localparam int PTR_W       = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(SPACE_DEPTH + 1);
    localparam int SUM_W       = PTR_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_WS   = 2'd2;
    localparam logic [1:0] KIND_FEND = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       eol;
    } cmd_t;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (SUM_W'(p) == SUM_W'(SPACE_DEPTH - 1))
            ptr_inc = '0;
        else
            ptr_inc = p + PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/csvqp_front.sv
`default_nettype none

module csvqp_front
    import csvqp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       queue_full,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_line,
    output logic            push,
    output cmd_t            push_cmd
);

    localparam logic [1:0] QM_OUT   = 2'd0;
    localparam logic [1:0] QM_IN    = 2'd1;
    localparam logic [1:0] QM_QUOTE = 2'd2;

    logic [1:0] quote_mode_reg;
    logic [1:0] quote_mode_next;
    logic [1:0] kind;
    logic       accept;

    assign accept = in_valid && !queue_full;

    always_comb
    begin
        quote_mode_next = quote_mode_reg;
        kind            = KIND_NONE;
        case (quote_mode_reg)
            QM_QUOTE:
            begin
                if (data_byte == CH_QUOTE)
                begin
                    quote_mode_next = QM_IN;
                    kind            = KIND_CHAR;
                end
                else if (data_byte == CH_COMMA)
                begin
                    quote_mode_next = QM_OUT;
                    kind            = KIND_FEND;
                end
                else
                begin
                    quote_mode_next = QM_OUT;
                    kind            = is_ws(data_byte) ? KIND_WS : KIND_CHAR;
                end
            end
            QM_IN:
            begin
                if (data_byte == CH_QUOTE)
                    quote_mode_next = QM_QUOTE;
                else
                    kind = is_ws(data_byte) ? KIND_WS : KIND_CHAR;
            end
            default:
            begin
                quote_mode_next = QM_OUT;
                if (data_byte == CH_QUOTE)
                    quote_mode_next = QM_IN;
                else if (data_byte == CH_COMMA)
                    kind = KIND_FEND;
                else
                    kind = is_ws(data_byte) ? KIND_WS : KIND_CHAR;
            end
        endcase
        if (end_of_line)
            quote_mode_next = QM_OUT;
    end

    // drop requests that cause no work at all
    assign push          = accept && ((kind != KIND_NONE) || end_of_line);
    assign push_cmd.kind = kind;
    assign push_cmd.data = data_byte;
    assign push_cmd.eol  = end_of_line;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quote_mode_reg <= QM_OUT;
        else if (accept)
            quote_mode_reg <= quote_mode_next;
    end

endmodule

`default_nettype wire

>>> rtl/csvqp_queue.sv
`default_nettype none

module csvqp_queue
    import csvqp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> rtl/csvqp_back.sv
`default_nettype none

module csvqp_back
    import csvqp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  wire cmd_t       cmd,
    output logic            cmd_pop,
    input  wire logic       out_stall,
    output logic            out_valid,
    output logic [7:0]      field_byte,
    output logic            has_byte,
    output logic            field_end,
    output logic            line_end,
    output logic            space_overflow,
    output logic            last_of_run
);

    logic [7:0]       space_reg [SPACE_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             seen_reg;
    logic             seen_next;
    logic             eol_phase_reg;
    logic             eol_phase_next;

    logic             out_valid_reg;
    logic [7:0]       byte_reg;
    logic             has_reg;
    logic             fend_reg;
    logic             lend_reg;
    logic             ovf_reg;
    logic             last_reg;

    logic             out_free;
    logic             emit;
    logic [7:0]       e_byte;
    logic             e_has;
    logic             e_fend;
    logic             e_lend;
    logic             e_ovf;
    logic             e_last;
    logic             finish;

    logic             buf_we;
    logic [PTR_W-1:0] buf_wa;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] tail;
    logic [7:0]       head_byte;

    assign out_free  = !out_valid_reg || !out_stall;
    assign head_byte = space_reg[head_reg];

    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_W'(SPACE_DEPTH))
            tail_sum = tail_sum - SUM_W'(SPACE_DEPTH);
        tail = tail_sum[PTR_W-1:0];
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        seen_next      = seen_reg;
        eol_phase_next = eol_phase_reg;
        cmd_pop        = 1'b0;
        emit           = 1'b0;
        e_byte         = 8'd0;
        e_has          = 1'b0;
        e_fend         = 1'b0;
        e_lend         = 1'b0;
        e_ovf          = 1'b0;
        e_last         = 1'b0;
        finish         = 1'b0;
        buf_we         = 1'b0;
        buf_wa         = tail;

        if (cmd_valid)
        begin
            if (eol_phase_reg)
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    e_fend         = 1'b1;
                    e_lend         = 1'b1;
                    e_last         = 1'b1;
                    count_next     = '0;
                    seen_next      = 1'b0;
                    eol_phase_next = 1'b0;
                    cmd_pop        = 1'b1;
                end
            end
            else
            begin
                case (cmd.kind)
                    KIND_CHAR:
                    begin
                        if (out_free)
                        begin
                            emit  = 1'b1;
                            e_has = 1'b1;
                            if (count_reg != '0)
                            begin
                                // flush held whitespace ahead of the byte
                                e_byte     = head_byte;
                                head_next  = ptr_inc(head_reg);
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                e_byte    = cmd.data;
                                e_last    = !cmd.eol;
                                seen_next = 1'b1;
                                finish    = 1'b1;
                            end
                        end
                    end
                    KIND_WS:
                    begin
                        if (!seen_reg)
                            finish = 1'b1;
                        else if (count_reg != CNT_W'(SPACE_DEPTH))
                        begin
                            buf_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            finish     = 1'b1;
                        end
                        else if (out_free)
                        begin
                            // full: push out the oldest, reuse its slot
                            emit      = 1'b1;
                            e_byte    = head_byte;
                            e_has     = 1'b1;
                            e_ovf     = 1'b1;
                            e_last    = !cmd.eol;
                            buf_we    = 1'b1;
                            buf_wa    = head_reg;
                            head_next = ptr_inc(head_reg);
                            finish    = 1'b1;
                        end
                    end
                    KIND_FEND:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            e_fend     = 1'b1;
                            e_last     = !cmd.eol;
                            count_next = '0;
                            seen_next  = 1'b0;
                            finish     = 1'b1;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
                if (finish)
                begin
                    if (cmd.eol)
                        eol_phase_next = 1'b1;
                    else
                        cmd_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            space_reg[buf_wa] <= cmd.data;
        if (emit)
        begin
            byte_reg <= e_byte;
            has_reg  <= e_has;
            fend_reg <= e_fend;
            lend_reg <= e_lend;
            ovf_reg  <= e_ovf;
            last_reg <= e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            eol_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            eol_phase_reg <= eol_phase_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign field_byte     = byte_reg;
    assign has_byte       = has_reg;
    assign field_end      = fend_reg;
    assign line_end       = lend_reg;
    assign space_overflow = ovf_reg;
    assign last_of_run    = last_reg;

endmodule

`default_nettype wire

>>> rtl/csv_quoted_field_parser_core.sv
`default_nettype none

// Channel  Handshake            Payload
// in       in_valid/in_stall    data_byte, end_of_line
// out      out_valid/out_stall  field_byte, has_byte, field_end, line_end,
//                               space_overflow, last_of_run
//
// The front takes one byte per cycle while the queue has room and resolves
// quoting in that cycle. Unless stalled, the back emits one result per
// cycle; held whitespace is emitted before a content byte, and a line end
// gets its own result. Held or dropped whitespace gives no result. A
// four-entry request queue lets input keep flowing while the back stalls.
// Reset clears quoting, the queue, the held-whitespace count and output.

module csv_quoted_field_parser_core
    import csvqp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_line,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      field_byte,
    output logic            has_byte,
    output logic            field_end,
    output logic            line_end,
    output logic            space_overflow,
    output logic            last_of_run
);

    logic queue_full;
    logic push;
    cmd_t push_cmd;
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    assign in_stall = queue_full;

    csvqp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .queue_full  (queue_full),
        .data_byte   (data_byte),
        .end_of_line (end_of_line),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    csvqp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    csvqp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (head_valid),
        .cmd            (head_cmd),
        .cmd_pop        (pop),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .field_byte     (field_byte),
        .has_byte       (has_byte),
        .field_end      (field_end),
        .line_end       (line_end),
        .space_overflow (space_overflow),
        .last_of_run    (last_of_run)
    );

endmodule

`default_nettype wire
